// File: sv/pfkp_pkg.sv
package pfkp_pkg;

  localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETH_TYPE_QINQ = 16'h88A8;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

  localparam logic [11:0] VLAN_ID_MASK  = 12'h0FFF;
  localparam logic [7:0]  TCP_FLAG_MASK = 8'h3F;

  typedef enum logic [1:0] {
    ST_IPV4      = 2'd0,
    ST_IPV6      = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_NOT_IP    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [11:0] vlan_tag;
    logic [7:0]  protocol;
    logic [5:0]  tcp_flag_bits;
    logic [15:0] tos_ttl;
    logic [15:0] packet_length;
  } out_item_t;

  // bytes of l4 header needed for the key
  function automatic logic [4:0] l4_needed(input logic [7:0] proto);
    logic [4:0] n;
    n = 5'd0;
    if (proto == PROTO_TCP)         n = 5'd20;
    else if (proto == PROTO_UDP)    n = 5'd8;
    else if (proto == PROTO_ICMP)   n = 5'd2;
    else if (proto == PROTO_ICMPV6) n = 5'd8;
    return n;
  endfunction

endpackage

// File: sv/packet_flow_key_parser_core.sv
// flow key parser: ethernet, optional single vlan tag, ipv4 or ipv6, then l4
// input channel: one frame byte per item on in_data, last_byte set on the
//   final byte; an item moves when in_valid is high and in_stall is low
// output channel: one flow key item per frame on out_data, presented on
//   out_valid and held until out_stall is low
// throughput: one byte per cycle while no last byte waits on a held result;
//   the per-frame state update is one short combinational step between the
//   input register and the state and result registers
// path: the key for a frame is formed as its last byte leaves the input
//   register, and the result register that takes it drives out_valid
// stall: a held result blocks only the next last byte; bytes inside a frame
//   keep flowing into the frame state while the result waits, and in_stall
//   rises only when a last byte finds the result register still occupied
// reset: rst_n low (synchronous) empties both registers and clears the
//   frame state, so the next byte accepted is offset zero of a new frame
// byte count runs in COUNT_WIDTH bits and saturates; packet_length is that
//   count clipped to 16 bits
module packet_flow_key_parser_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfkp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pfkp_pkg::out_item_t out_data
);
  import pfkp_pkg::*;

  in_item_t  item;
  out_item_t result;
  logic      advance;
  logic      out_free;

  // input register with the stall decision
  pfkp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_free (out_free),
    .item     (item),
    .advance  (advance)
  );

  // frame state, field capture and verdict
  pfkp_field_capture #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_field_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  // result register, loaded on the last byte of a frame
  pfkp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && item.last_byte),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: sv/pfkp_in_stage.sv
module pfkp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfkp_pkg::in_item_t in_data,
  input  logic               out_free,
  output pfkp_pkg::in_item_t item,
  output logic               advance
);
  import pfkp_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     accept;

  // a non-last byte never waits; the last byte needs a free result slot
  assign advance  = valid_r && (!item_r.last_byte || out_free);
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
  end

endmodule

// File: sv/pfkp_field_capture.sv
module pfkp_field_capture #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  pfkp_pkg::in_item_t  item,
  output pfkp_pkg::out_item_t result
);
  import pfkp_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] OFF_ETYPE_HI = COUNT_WIDTH'(12);
  localparam logic [COUNT_WIDTH-1:0] OFF_ETYPE_LO = COUNT_WIDTH'(13);
  localparam logic [COUNT_WIDTH-1:0] OFF_TAG_HI   = COUNT_WIDTH'(14);
  localparam logic [COUNT_WIDTH-1:0] OFF_TAG_LO   = COUNT_WIDTH'(15);
  localparam logic [COUNT_WIDTH-1:0] OFF_INNER_HI = COUNT_WIDTH'(16);
  localparam logic [COUNT_WIDTH-1:0] OFF_INNER_LO = COUNT_WIDTH'(17);
  localparam logic [7:0] L3_UNTAGGED = 8'd14;
  localparam logic [7:0] L3_TAGGED   = 8'd18;

  logic [COUNT_WIDTH-1:0] off_r;
  logic [15:0]            ether_kind_r, ek;
  logic                   tagged_r, tg;
  logic [11:0]            vlan_r, vl;
  logic [3:0]             ihl_r, ihl;
  logic [7:0]             proto_r, pr;
  logic [15:0][7:0]       src_r, src;
  logic [15:0][7:0]       dst_r, dst;
  logic [3:0][7:0]        ports_r, po;
  logic [5:0]             flags_r, fl;
  logic [15:0]            tos_ttl_r, tt;

  logic [7:0]             b;
  logic [7:0]             l3;
  logic [COUNT_WIDTH-1:0] rel;
  logic [COUNT_WIDTH-1:0] lrel;
  logic [COUNT_WIDTH-1:0] count;
  logic [7:0]             v4_end;
  logic [7:0]             v6_end;
  logic [1:0]             st;
  logic                   clear;

  assign b     = item.data_byte;
  assign clear = advance && item.last_byte;
  assign count = (&off_r) ? off_r : off_r + 1'b1;

  // next frame state for this byte
  always_comb begin
    ek   = ether_kind_r;
    tg   = tagged_r;
    vl   = vlan_r;
    ihl  = ihl_r;
    pr   = proto_r;
    src  = src_r;
    dst  = dst_r;
    po   = ports_r;
    fl   = flags_r;
    tt   = tos_ttl_r;
    lrel = '0;

    if (off_r == OFF_ETYPE_HI || off_r == OFF_ETYPE_LO ||
        (tagged_r && (off_r == OFF_INNER_HI || off_r == OFF_INNER_LO))) begin
      ek = {ek[7:0], b};
    end
    if (off_r == OFF_ETYPE_LO && (ek == ETH_TYPE_VLAN || ek == ETH_TYPE_QINQ)) begin
      tg = 1'b1;
    end
    if (tg && off_r == OFF_TAG_HI) begin
      vl = {b[3:0], 8'h00};
    end
    if (tg && off_r == OFF_TAG_LO) begin
      vl = (vl | {4'h0, b}) & VLAN_ID_MASK;
    end

    l3  = tg ? L3_TAGGED : L3_UNTAGGED;
    rel = off_r - COUNT_WIDTH'(l3);

    if (off_r >= COUNT_WIDTH'(l3)) begin
      if (ek == ETH_TYPE_IPV4) begin
        if (rel == COUNT_WIDTH'(0)) begin
          ihl = b[3:0];
        end else if (rel == COUNT_WIDTH'(1)) begin
          tt[15:8] = b;
        end else if (rel == COUNT_WIDTH'(8)) begin
          tt[7:0] = b;
        end else if (rel == COUNT_WIDTH'(9)) begin
          pr = b;
        end else if (rel >= COUNT_WIDTH'(12) && rel <= COUNT_WIDTH'(15)) begin
          src[{2'b11, ~rel[1:0]}] = src[{2'b11, ~rel[1:0]}] | b;
        end else if (rel >= COUNT_WIDTH'(16) && rel <= COUNT_WIDTH'(19)) begin
          dst[{2'b11, ~rel[1:0]}] = dst[{2'b11, ~rel[1:0]}] | b;
        end
        lrel = rel - COUNT_WIDTH'({ihl, 2'b00});
        if (ihl >= 4'd5 && rel >= COUNT_WIDTH'({ihl, 2'b00})) begin
          if (lrel < COUNT_WIDTH'(4)) begin
            po[~lrel[1:0]] = po[~lrel[1:0]] | b;
          end else if (lrel == COUNT_WIDTH'(13) && pr == PROTO_TCP) begin
            fl = b[5:0];
          end
        end
      end else if (ek == ETH_TYPE_IPV6) begin
        lrel = rel - COUNT_WIDTH'(40);
        if (rel == COUNT_WIDTH'(6)) begin
          pr = b;
        end else if (rel == COUNT_WIDTH'(7)) begin
          tt = {8'h00, b};
        end else if (rel >= COUNT_WIDTH'(8) && rel <= COUNT_WIDTH'(23)) begin
          // byte k of the address sits in element 15-k
          src[~{~rel[3], rel[2:0]}] = src[~{~rel[3], rel[2:0]}] | b;
        end else if (rel >= COUNT_WIDTH'(24) && rel <= COUNT_WIDTH'(39)) begin
          dst[~{~rel[3], rel[2:0]}] = dst[~{~rel[3], rel[2:0]}] | b;
        end else if (rel >= COUNT_WIDTH'(40)) begin
          if (lrel < COUNT_WIDTH'(4)) begin
            po[~lrel[1:0]] = po[~lrel[1:0]] | b;
          end else if (lrel == COUNT_WIDTH'(13) && pr == PROTO_TCP) begin
            fl = b[5:0];
          end
        end
      end
    end
  end

  // frame verdict on the updated state
  assign v4_end = l3 + {2'b00, ihl, 2'b00} + {3'b000, l4_needed(pr)};
  assign v6_end = l3 + 8'd40 + {3'b000, l4_needed(pr)};

  always_comb begin
    priority if (count < COUNT_WIDTH'(L3_UNTAGGED)) begin
      st = ST_MALFORMED;
    end else if (tg && count < COUNT_WIDTH'(L3_TAGGED)) begin
      st = ST_MALFORMED;
    end else if (ek == ETH_TYPE_IPV4) begin
      if (count < COUNT_WIDTH'(l3 + 8'd20) || ihl < 4'd5 ||
          count < COUNT_WIDTH'(v4_end)) begin
        st = ST_MALFORMED;
      end else begin
        st = ST_IPV4;
      end
    end else if (ek == ETH_TYPE_IPV6) begin
      if (count < COUNT_WIDTH'(v6_end)) begin
        st = ST_MALFORMED;
      end else begin
        st = ST_IPV6;
      end
    end else begin
      st = ST_NOT_IP;
    end
  end

  always_comb begin
    result               = '0;
    result.status        = st;
    result.packet_length = (32'(count) > 32'hFFFF) ? 16'hFFFF : 16'(count);
    if (st == ST_IPV4 || st == ST_IPV6) begin
      result.src_addr_high = src[15:8];
      result.src_addr_low  = src[7:0];
      result.dst_addr_high = dst[15:8];
      result.dst_addr_low  = dst[7:0];
      if (pr == PROTO_TCP || pr == PROTO_UDP) begin
        result.l4_sport = po[3:2];
        result.l4_dport = po[1:0];
      end else if (pr == PROTO_ICMP || pr == PROTO_ICMPV6) begin
        result.l4_sport = po[3:2];
      end
      result.vlan_tag      = vl;
      result.protocol      = pr;
      result.tcp_flag_bits = (pr == PROTO_TCP) ? (fl & TCP_FLAG_MASK[5:0]) : 6'd0;
      result.tos_ttl       = tt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      off_r        <= '0;
      ether_kind_r <= '0;
      tagged_r     <= 1'b0;
      vlan_r       <= '0;
      ihl_r        <= '0;
      proto_r      <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      ports_r      <= '0;
      flags_r      <= '0;
      tos_ttl_r    <= '0;
    end else if (advance) begin
      off_r        <= count;
      ether_kind_r <= ek;
      tagged_r     <= tg;
      vlan_r       <= vl;
      ihl_r        <= ihl;
      proto_r      <= pr;
      src_r        <= src;
      dst_r        <= dst;
      ports_r      <= po;
      flags_r      <= fl;
      tos_ttl_r    <= tt;
    end
  end

endmodule

// File: sv/pfkp_out_reg.sv
module pfkp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pfkp_pkg::out_item_t result,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output pfkp_pkg::out_item_t out_data
);
  import pfkp_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // slot frees in the same cycle its item is taken
  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

// File: tb/sv/packet_flow_key_parser_core_tb.sv
module packet_flow_key_parser_core_tb;
  import pfkp_pkg::*;

  // codes that only the bench uses, not the design
  localparam logic [15:0] NO_TAG         = 16'h0000;
  localparam logic [15:0] ETH_TYPE_NONE  = 16'h0000;
  localparam logic [15:0] ETH_TYPE_OTHER = 16'h88B5;
  localparam logic [7:0]  PROTO_NONE     = 8'd0;
  localparam logic [7:0]  PROTO_NO_NEXT  = 8'd59;
  localparam logic [7:0]  PROTO_RESERVED = 8'd255;
  localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

  localparam int WATCHDOG_LIMIT  = 300;
  localparam int TOTAL_BYTES     = 1150;
  localparam int RAND_FRAMES_MIN = 4;
  localparam int DRAIN_CYCLES    = 4;

  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_RAND
  } fill_t;

  // one frame to build: header fields go on top of the fill pattern, then the
  // frame is cut to len bytes
  typedef struct packed {
    logic [16:0] len;
    logic [15:0] tag_type;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    fill_t       fill;
    logic        typed;
    status_t     want;
  } frame_spec_t;

  localparam int N_DIR = 23;
  // typed rows carry status and length only, every other field is zero
  localparam frame_spec_t DIRECTED [N_DIR] = '{
    '{17'd1,     NO_TAG,        ETH_TYPE_NONE,  4'd0,  PROTO_NONE,     FILL_ZERO, 1'b1, ST_MALFORMED},
    '{17'd13,    NO_TAG,        ETH_TYPE_IPV4,  4'd5,  PROTO_TCP,      FILL_ONES, 1'b1, ST_MALFORMED},
    '{17'd14,    NO_TAG,        ETH_TYPE_OTHER, 4'd0,  PROTO_NONE,     FILL_ZERO, 1'b1, ST_NOT_IP},
    '{17'd16,    ETH_TYPE_VLAN, ETH_TYPE_IPV4,  4'd5,  PROTO_TCP,      FILL_RAND, 1'b1, ST_MALFORMED},
    '{17'd30,    NO_TAG,        ETH_TYPE_IPV4,  4'd5,  PROTO_TCP,      FILL_RAND, 1'b1, ST_MALFORMED},
    '{17'd60,    NO_TAG,        ETH_TYPE_IPV4,  4'd4,  PROTO_TCP,      FILL_RAND, 1'b1, ST_MALFORMED},
    '{17'd60,    NO_TAG,        ETH_TYPE_IPV4,  4'd0,  PROTO_UDP,      FILL_ONES, 1'b1, ST_MALFORMED},
    '{17'd54,    NO_TAG,        ETH_TYPE_IPV4,  4'd15, PROTO_NO_NEXT,  FILL_RAND, 1'b1, ST_MALFORMED},
    '{17'd54,    NO_TAG,        ETH_TYPE_IPV4,  4'd5,  PROTO_TCP,      FILL_RAND, 1'b0, ST_IPV4},
    '{17'd53,    NO_TAG,        ETH_TYPE_IPV4,  4'd5,  PROTO_TCP,      FILL_RAND, 1'b1, ST_MALFORMED},
    '{17'd46,    ETH_TYPE_QINQ, ETH_TYPE_IPV4,  4'd5,  PROTO_UDP,      FILL_ONES, 1'b0, ST_IPV4},
    '{17'd36,    NO_TAG,        ETH_TYPE_IPV4,  4'd5,  PROTO_ICMP,     FILL_ZERO, 1'b0, ST_IPV4},
    '{17'd42,    NO_TAG,        ETH_TYPE_IPV4,  4'd5,  PROTO_ICMPV6,   FILL_RAND, 1'b0, ST_IPV4},
    '{17'd56,    NO_TAG,        ETH_TYPE_IPV6,  4'd0,  PROTO_ICMP,     FILL_RAND, 1'b0, ST_IPV6},
    '{17'd78,    ETH_TYPE_VLAN, ETH_TYPE_IPV6,  4'd0,  PROTO_TCP,      FILL_ONES, 1'b0, ST_IPV6},
    '{17'd61,    NO_TAG,        ETH_TYPE_IPV6,  4'd0,  PROTO_UDP,      FILL_RAND, 1'b1, ST_MALFORMED},
    '{17'd54,    NO_TAG,        ETH_TYPE_IPV6,  4'd0,  PROTO_NO_NEXT,  FILL_RAND, 1'b0, ST_IPV6},
    '{17'd94,    NO_TAG,        ETH_TYPE_IPV4,  4'd15, PROTO_TCP,      FILL_RAND, 1'b0, ST_IPV4},
    '{17'd64,    ETH_TYPE_VLAN, ETH_TYPE_VLAN,  4'd5,  PROTO_TCP,      FILL_RAND, 1'b1, ST_NOT_IP},
    '{17'd53,    NO_TAG,        ETH_TYPE_IPV6,  4'd0,  PROTO_TCP,      FILL_RAND, 1'b1, ST_MALFORMED},
    '{17'd64,    NO_TAG,        ETH_TYPE_OTHER, 4'd0,  PROTO_NONE,     FILL_ONES, 1'b1, ST_NOT_IP},
    '{17'd34,    NO_TAG,        ETH_TYPE_IPV4,  4'd5,  PROTO_RESERVED, FILL_ONES, 1'b0, ST_IPV4},
    '{17'd66,    ETH_TYPE_QINQ, ETH_TYPE_IPV6,  4'd0,  PROTO_ICMPV6,   FILL_ZERO, 1'b0, ST_IPV6}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  packet_flow_key_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // parser state as the block should hold it
  logic [15:0]  cur_off;
  logic [15:0]  cur_etype;
  logic         cur_tagged;
  logic [11:0]  cur_vid;
  logic [3:0]   cur_ihl;
  logic [7:0]   cur_proto;
  logic [127:0] cur_src;
  logic [127:0] cur_dst;
  logic [31:0]  cur_l4;
  logic [5:0]   cur_tflags;
  logic [15:0]  cur_tos_ttl;

  out_item_t   pending_keys[$];
  logic [7:0]  frame_buf[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int unsigned stall_left = 0;
  int          bytes_sent = 0;
  int          frames_rand;

  function automatic int l4_key_bytes(logic [7:0] proto);
    if (proto == PROTO_TCP) return 20;
    if (proto == PROTO_UDP) return 8;
    if (proto == PROTO_ICMP) return 2;
    if (proto == PROTO_ICMPV6) return 8;
    return 0;
  endfunction

  function automatic void clear_frame_state();
    cur_off = '0;
    cur_etype = '0;
    cur_tagged = 1'b0;
    cur_vid = '0;
    cur_ihl = '0;
    cur_proto = '0;
    cur_src = '0;
    cur_dst = '0;
    cur_l4 = '0;
    cur_tflags = '0;
    cur_tos_ttl = '0;
  endfunction

  function automatic void take_l4(int lrel, logic [7:0] b);
    if (lrel < 4) cur_l4[31 - 8*lrel -: 8] |= b;
    else if (lrel == 13 && cur_proto == PROTO_TCP) cur_tflags = b[5:0];
  endfunction

  // advance the frame state by one byte; on the last byte hand back the key
  task automatic parse_byte(input logic [7:0] b, input logic last, output logic got,
                            output out_item_t key);
    int          off, l3, rel, hlen, len, need;
    status_t     st;
    logic [15:0] cnt;
    got = 1'b0;
    key = '0;
    off = int'(cur_off);
    if (off == 12 || off == 13 || (cur_tagged && (off == 16 || off == 17)))
      cur_etype = {cur_etype[7:0], b};
    if (off == 13 && (cur_etype == ETH_TYPE_VLAN || cur_etype == ETH_TYPE_QINQ))
      cur_tagged = 1'b1;
    if (cur_tagged && off == 14) cur_vid = {b[3:0], 8'h00};
    if (cur_tagged && off == 15) cur_vid[7:0] = b;
    l3 = cur_tagged ? 18 : 14;
    if (off >= l3) begin
      rel = off - l3;
      if (cur_etype == ETH_TYPE_IPV4) begin
        if (rel == 0) cur_ihl = b[3:0];
        else if (rel == 1) cur_tos_ttl[15:8] = b;
        else if (rel == 8) cur_tos_ttl[7:0] = b;
        else if (rel == 9) cur_proto = b;
        else if (rel >= 12 && rel <= 15) cur_src[127 - 8*(rel-12) -: 8] |= b;
        else if (rel >= 16 && rel <= 19) cur_dst[127 - 8*(rel-16) -: 8] |= b;
        hlen = int'(cur_ihl) * 4;
        if (cur_ihl >= 4'd5 && rel >= hlen) take_l4(rel - hlen, b);
      end else if (cur_etype == ETH_TYPE_IPV6) begin
        if (rel == 6) cur_proto = b;
        else if (rel == 7) cur_tos_ttl = {8'h00, b};
        else if (rel >= 8 && rel <= 23) cur_src[127 - 8*(rel-8) -: 8] |= b;
        else if (rel >= 24 && rel <= 39) cur_dst[127 - 8*(rel-24) -: 8] |= b;
        else if (rel >= 40) take_l4(rel - 40, b);
      end
    end
    cnt = (cur_off != OFFSET_MAX) ? cur_off + 16'd1 : cur_off;
    if (!last) begin
      cur_off = cnt;
      return;
    end

    len = int'(cnt);
    need = l4_key_bytes(cur_proto);
    if (len < 14 || (cur_tagged && len < 18)) st = ST_MALFORMED;
    else if (cur_etype == ETH_TYPE_IPV4) begin
      if (len < l3 + 20 || cur_ihl < 4'd5 || len < l3 + int'(cur_ihl) * 4 + need)
        st = ST_MALFORMED;
      else st = ST_IPV4;
    end else if (cur_etype == ETH_TYPE_IPV6) begin
      st = (len < l3 + 40 + need) ? ST_MALFORMED : ST_IPV6;
    end else st = ST_NOT_IP;

    key.status = st;
    key.packet_length = cnt;
    if (st == ST_IPV4 || st == ST_IPV6) begin
      key.src_addr_high = cur_src[127:64];
      key.src_addr_low  = cur_src[63:0];
      key.dst_addr_high = cur_dst[127:64];
      key.dst_addr_low  = cur_dst[63:0];
      if (cur_proto == PROTO_TCP || cur_proto == PROTO_UDP) begin
        key.l4_sport = cur_l4[31:16];
        key.l4_dport = cur_l4[15:0];
      end else if (cur_proto == PROTO_ICMP || cur_proto == PROTO_ICMPV6) begin
        key.l4_sport = cur_l4[31:16];
      end
      key.vlan_tag = cur_vid;
      key.protocol = cur_proto;
      key.tcp_flag_bits = (cur_proto == PROTO_TCP) ? cur_tflags : 6'd0;
      key.tos_ttl = cur_tos_ttl;
    end
    got = 1'b1;
    clear_frame_state();
  endtask

  function automatic void check_key(out_item_t want, out_item_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.src_addr_high !== want.src_addr_high) begin
      $error("src_addr_high: expected %h, got %h", want.src_addr_high, got.src_addr_high);
      mismatches++;
    end
    if (got.src_addr_low !== want.src_addr_low) begin
      $error("src_addr_low: expected %h, got %h", want.src_addr_low, got.src_addr_low);
      mismatches++;
    end
    if (got.dst_addr_high !== want.dst_addr_high) begin
      $error("dst_addr_high: expected %h, got %h", want.dst_addr_high, got.dst_addr_high);
      mismatches++;
    end
    if (got.dst_addr_low !== want.dst_addr_low) begin
      $error("dst_addr_low: expected %h, got %h", want.dst_addr_low, got.dst_addr_low);
      mismatches++;
    end
    if (got.l4_sport !== want.l4_sport) begin
      $error("l4_sport: expected %h, got %h", want.l4_sport, got.l4_sport);
      mismatches++;
    end
    if (got.l4_dport !== want.l4_dport) begin
      $error("l4_dport: expected %h, got %h", want.l4_dport, got.l4_dport);
      mismatches++;
    end
    if (got.vlan_tag !== want.vlan_tag) begin
      $error("vlan_tag: expected %h, got %h", want.vlan_tag, got.vlan_tag);
      mismatches++;
    end
    if (got.protocol !== want.protocol) begin
      $error("protocol: expected %0d, got %0d", want.protocol, got.protocol);
      mismatches++;
    end
    if (got.tcp_flag_bits !== want.tcp_flag_bits) begin
      $error("tcp_flag_bits: expected %h, got %h", want.tcp_flag_bits, got.tcp_flag_bits);
      mismatches++;
    end
    if (got.tos_ttl !== want.tos_ttl) begin
      $error("tos_ttl: expected %h, got %h", want.tos_ttl, got.tos_ttl);
      mismatches++;
    end
    if (got.packet_length !== want.packet_length) begin
      $error("packet_length: expected %0d, got %0d", want.packet_length, got.packet_length);
      mismatches++;
    end
  endfunction

  function automatic void put_byte(int p, logic [7:0] v);
    if (p < frame_buf.size()) frame_buf[p] = v;
  endfunction

  task automatic build_frame(input frame_spec_t s);
    int l3;
    frame_buf.delete();
    for (int i = 0; i < int'(s.len); i++) begin
      case (s.fill)
        FILL_ZERO: frame_buf.push_back(8'h00);
        FILL_ONES: frame_buf.push_back(8'hFF);
        default:   frame_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (s.tag_type != NO_TAG) begin
      put_byte(12, s.tag_type[15:8]);
      put_byte(13, s.tag_type[7:0]);
      put_byte(16, s.etype[15:8]);
      put_byte(17, s.etype[7:0]);
      l3 = 18;
    end else begin
      put_byte(12, s.etype[15:8]);
      put_byte(13, s.etype[7:0]);
      l3 = 14;
    end
    // ipv4 keeps the version nibble the fill put there; ipv6 sets it to 6
    if (l3 < frame_buf.size()) begin
      if (s.etype == ETH_TYPE_IPV4) begin
        put_byte(l3, {frame_buf[l3][7:4], s.ihl});
        put_byte(l3 + 9, s.proto);
      end else if (s.etype == ETH_TYPE_IPV6) begin
        put_byte(l3, {4'h6, frame_buf[l3][3:0]});
        put_byte(l3 + 6, s.proto);
      end
    end
  endtask

  // mostly complete frames with random content, the rest cut short or bent
  function automatic frame_spec_t draw_frame();
    frame_spec_t s;
    int          l3, hlen, full;
    s = '0;
    case ($urandom_range(0, 3))
      2:       s.tag_type = ETH_TYPE_VLAN;
      3:       s.tag_type = ETH_TYPE_QINQ;
      default: s.tag_type = NO_TAG;
    endcase
    s.etype = ($urandom_range(0, 1) == 0) ? ETH_TYPE_IPV4 : ETH_TYPE_IPV6;
    s.ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    case ($urandom_range(0, 5))
      0, 4:    s.proto = PROTO_TCP;
      1:       s.proto = PROTO_UDP;
      2:       s.proto = PROTO_ICMP;
      3:       s.proto = PROTO_ICMPV6;
      default: s.proto = 8'($urandom_range(0, 255));
    endcase
    l3 = (s.tag_type != NO_TAG) ? 18 : 14;
    hlen = (s.etype == ETH_TYPE_IPV4) ? int'(s.ihl) * 4 : 40;
    full = l3 + hlen + l4_key_bytes(s.proto) + int'($urandom_range(0, 10));
    s.len = 17'(full);
    s.fill = FILL_RAND;
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: s.len = 17'($urandom_range(1, full));
        1: s.etype = 16'($urandom_range(0, 16'hFFFF));
        2: s.ihl = 4'($urandom_range(0, 4));
        default: begin
          s.tag_type = ETH_TYPE_VLAN;
          s.etype = ($urandom_range(0, 1) == 0) ? ETH_TYPE_VLAN : ETH_TYPE_QINQ;
        end
      endcase
    end
    return s;
  endfunction

  // one byte onto the input channel, returns once it is taken
  task automatic send_byte(input logic [7:0] b, input logic last, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input frame_spec_t s);
    logic      got;
    out_item_t key;
    bit        no_gap;
    build_frame(s);
    // long frames and some others go through back to back
    no_gap = (s.len > 17'd1000) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1, no_gap);
      parse_byte(frame_buf[i], i == frame_buf.size() - 1, got, key);
      bytes_sent++;
      if (got) begin
        if (s.typed) begin
          key = '0;
          key.status = s.want;
          key.packet_length = s.len[15:0];
        end
        pending_keys.push_back(key);
      end
    end
  endtask

  // result side: check each taken key, then hold stall for a random stretch
  always @(posedge clk) begin : key_sink
    int unsigned hold;
    if (out_valid && !out_stall) begin
      if (pending_keys.size() == 0) begin
        $error("flow key arrived with none pending");
        mismatches++;
      end else begin
        check_key(pending_keys.pop_front(), out_data);
      end
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      stall_left <= hold;
      out_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  // ends a run that stops moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    clear_frame_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) send_frame(DIRECTED[r]);

    frames_rand = 0;
    while (bytes_sent < TOTAL_BYTES || frames_rand < RAND_FRAMES_MIN) begin
      send_frame(draw_frame());
      frames_rand++;
    end
    in_valid <= 1'b0;

    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
